[design/dssd_pkg.sv]
// Types, codes and constants shared by the decimal seven-segment driver.
`timescale 1ns / 1ps

package dssd_pkg;

  // Largest number of digits the display can carry.
  localparam int unsigned MAX_DIGITS = 20;
  localparam logic [4:0] NUM_DIGITS_RESET = 5'd8;

  // The divide-by-ten unit walks the 64-bit value in 16-bit chunks.
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned NUM_CHUNKS = VALUE_W / CHUNK_W;
  localparam int unsigned CHUNK_CNT_W = $clog2(NUM_CHUNKS);
  localparam int unsigned DIVIDEND_W = CHUNK_W + 4;
  // ceil(2^23 / 10): exact quotient for every dividend below 10 * 2^16.
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [DIVIDEND_W-1:0] RECIP_TEN = 20'hCCCCD;

  localparam logic [7:0] BLANK_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    MODE_NUMBER = 2'd0,
    MODE_DIGIT  = 2'd1,
    MODE_RAW    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [63:0] number;
    logic [7:0]  dp_mask;
    logic [4:0]  digit_index;
    logic [3:0]  digit_value;
    logic        digit_dp;
    logic [7:0]  raw_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] unit_index;
    logic       port_b;
    logic [7:0] port_data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic       last_step;
    logic [3:0] digit;
  } div_stat_t;

  // Active-low segment byte for a decimal digit, bit 7 being the point.
  function automatic logic [7:0] seg_byte(input logic [3:0] value, input logic point);
    logic [6:0] segs;
    case (value)
      4'd0: segs = 7'h3F;
      4'd1: segs = 7'h06;
      4'd2: segs = 7'h5B;
      4'd3: segs = 7'h4F;
      4'd4: segs = 7'h66;
      4'd5: segs = 7'h6D;
      4'd6: segs = 7'h7D;
      4'd7: segs = 7'h07;
      4'd8: segs = 7'h7F;
      4'd9: segs = 7'h6F;
      default: segs = 7'h00;
    endcase
    return ~{point, segs};
  endfunction

endpackage

[design/dssd_div10.sv]
// Iterative divide-by-ten unit that works one 16-bit chunk per cycle while its step input is high.
`timescale 1ns / 1ps

module dssd_div10 import dssd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_ctrl_t          ctrl_i,
  input  logic [VALUE_W-1:0] value_i,
  output div_stat_t          stat_o
);

  logic [VALUE_W-1:0]     quot_q, quot_d;
  logic [3:0]             rem_q, rem_d;
  logic [CHUNK_CNT_W-1:0] cnt_q, cnt_d;

  logic [CHUNK_CNT_W-1:0]   chunk_idx;
  logic [CHUNK_W-1:0]       chunk;
  logic [3:0]               rem_in;
  logic [DIVIDEND_W-1:0]    dividend;
  logic [2*DIVIDEND_W-1:0]  product;
  logic [CHUNK_W-1:0]       chunk_quot;
  logic [DIVIDEND_W-1:0]    times_ten;
  logic [DIVIDEND_W-1:0]    diff;

  // Long division from the most significant chunk down; the remainder of
  // one chunk feeds the next, starting from zero for each new digit.
  assign chunk_idx  = CHUNK_CNT_W'(NUM_CHUNKS - 1) - cnt_q;
  assign chunk      = quot_q[chunk_idx*CHUNK_W +: CHUNK_W];
  assign rem_in     = (cnt_q == '0) ? 4'd0 : rem_q;
  assign dividend   = {rem_in, chunk};
  assign product    = (2*DIVIDEND_W)'(dividend) * (2*DIVIDEND_W)'(RECIP_TEN);
  assign chunk_quot = product[RECIP_SHIFT +: CHUNK_W];
  assign times_ten  = {1'b0, chunk_quot, 3'b000} + {3'b000, chunk_quot, 1'b0};
  assign diff       = dividend - times_ten;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (ctrl_i.load) begin
      quot_d = value_i;
      cnt_d  = '0;
    end else if (ctrl_i.step) begin
      quot_d[chunk_idx*CHUNK_W +: CHUNK_W] = chunk_quot;
      rem_d = diff[3:0];
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign stat_o.last_step = (cnt_q == CHUNK_CNT_W'(NUM_CHUNKS - 1));
  assign stat_o.digit     = rem_q;

endmodule

[design/decimal_seven_segment_driver.sv]
// Top level of the decimal seven-segment driver: sequencer and result register.
`timescale 1ns / 1ps
// Number mode runs 4 chunk steps of the shared divide-by-ten unit for each
// fitted digit and then registers that digit's result.
// Clear mode registers one result per digit; digit and raw modes a single one.
// One transaction is worked at a time; a stalled result holds the sequencer.
// Reset is asynchronous and active low; the digit count returns to eight.

module decimal_seven_segment_driver import dssd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  // Configuration: number of digits fitted, clamped to what the display
  // supports before it is used anywhere.
  logic [4:0] num_digits_q;
  logic [4:0] eff_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_digits_q <= NUM_DIGITS_RESET;
    end else if (cfg_we_i) begin
      num_digits_q <= cfg_wdata_i;
    end
  end

  assign eff_count = (num_digits_q > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS) : num_digits_q;

  // Sequencer state and the fields of the transaction in progress.
  state_e     state_q, state_d;
  mode_e      mode_q;
  logic [4:0] dig_cnt_q, dig_cnt_d;
  logic [7:0] data_q;
  logic [7:0] point_bits_q;

  logic      accept;
  logic      slot_free;
  logic      out_load;
  logic      emit_last;
  logic      item_valid;
  div_ctrl_t div_ctrl;
  div_stat_t div_stat;

  out_item_t out_data_q;
  logic      out_valid_q;

  // The shared divide-by-ten unit holds the running quotient.
  dssd_div10 u_div10 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .value_i (in_data_i.number),
    .stat_o  (div_stat)
  );

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // The result register can take a new result when it is empty or when its
  // current result leaves in this cycle.
  assign slot_free = !out_valid_q || !out_stall_i;

  // Whether the incoming transaction causes any result at all. Number and
  // clear modes need at least one digit; single writes need an index in
  // range, and a digit write also needs a decimal value.
  always_comb begin
    case (in_data_i.mode)
      MODE_NUMBER, MODE_CLEAR: item_valid = (eff_count != 5'd0);
      MODE_DIGIT: item_valid = (in_data_i.digit_value <= 4'd9) &&
                               (in_data_i.digit_index < eff_count);
      MODE_RAW:   item_valid = (in_data_i.digit_index < eff_count);
      default:    item_valid = 1'b0;
    endcase
  end

  // A single write ends at once; the sweeps end on the last fitted digit.
  assign emit_last = (mode_q == MODE_DIGIT) || (mode_q == MODE_RAW) ||
                     (dig_cnt_q == 5'(eff_count - 5'd1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && item_valid) begin
          state_d = (in_data_i.mode == MODE_NUMBER) ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_stat.last_step) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (emit_last) begin
            state_d = ST_IDLE;
          end else if (mode_q == MODE_NUMBER) begin
            state_d = ST_DIV;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: divider control, result load and digit counter.
  always_comb begin
    div_ctrl  = '0;
    out_load  = 1'b0;
    dig_cnt_d = dig_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          div_ctrl.load = 1'b1;
          if ((in_data_i.mode == MODE_DIGIT) || (in_data_i.mode == MODE_RAW)) begin
            dig_cnt_d = in_data_i.digit_index;
          end else begin
            dig_cnt_d = 5'd0;
          end
        end
      end
      ST_DIV: begin
        div_ctrl.step = 1'b1;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (!emit_last) begin
            dig_cnt_d = dig_cnt_q + 5'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction fields. For single writes the final byte is formed at
  // acceptance; clear mode always sends a blank digit.
  always_ff @(posedge clk_i) begin
    dig_cnt_q <= dig_cnt_d;
    if (accept) begin
      mode_q       <= in_data_i.mode;
      point_bits_q <= in_data_i.dp_mask;
      case (in_data_i.mode)
        MODE_DIGIT: data_q <= seg_byte(in_data_i.digit_value, in_data_i.digit_dp);
        MODE_RAW:   data_q <= in_data_i.raw_byte;
        default:    data_q <= BLANK_BYTE;
      endcase
    end
  end

  // Result byte: number mode takes the digit the divider has just left and
  // lights the point only for the first eight digits.
  logic       number_point;
  logic [7:0] emit_data;

  assign number_point = (dig_cnt_q < 5'd8) && point_bits_q[dig_cnt_q[2:0]];
  assign emit_data    = (mode_q == MODE_NUMBER) ? seg_byte(div_stat.digit, number_point)
                                                : data_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.unit_index <= dig_cnt_q[4:1];
      out_data_q.port_b     <= dig_cnt_q[0];
      out_data_q.port_data  <= emit_data;
      out_data_q.last       <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[dv/tb_decimal_seven_segment_driver.sv]
// Self-checking testbench for the decimal seven-segment driver.
`timescale 1ns / 1ps

module tb_decimal_seven_segment_driver;
  import dssd_pkg::*;

  // A number-mode transaction on a full display is the longest one, so
  // this many quiet cycles are enough for the block to settle after its
  // last display write.
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned ITEMS_PER_PHASE = 24;
  localparam int unsigned NUM_PHASES = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;

  decimal_seven_segment_driver uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The stimulus process fills this queue; the driver takes from its head.
  in_item_t    pending_items[$];
  // Display writes the block owes us, oldest first.
  out_item_t   display_writes_due[$];
  // Our own copy of the digit count register.
  logic [4:0]  num_digits_shadow = NUM_DIGITS_RESET;

  int unsigned items_queued = 0;
  int unsigned items_offered = 0;
  int unsigned items_accepted = 0;
  int unsigned writes_taken = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Idling knobs: the largest gap the sender may draw per transaction and the receiver per display write.
  int unsigned send_gap_max = 0;
  int unsigned recv_gap_max = 0;
  // Each increment asks the receiver for one long hold-off.
  int unsigned hold_requests = 0;

  int unsigned phase_counts [NUM_PHASES] = '{20, 1, 13, 5, 31, 8, 0, 2};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // A digit count above the largest display simply fills the whole display.
  function automatic int unsigned fitted_of(logic [4:0] count);
    return (count > MAX_DIGITS) ? MAX_DIGITS : int'(count);
  endfunction

  // Active-low segment byte for one decimal digit, the point on bit 7.
  function automatic logic [7:0] lit_segments(int unsigned d, logic point);
    logic [6:0] pattern;
    case (d)
      0: pattern = 7'h3F;
      1: pattern = 7'h06;
      2: pattern = 7'h5B;
      3: pattern = 7'h4F;
      4: pattern = 7'h66;
      5: pattern = 7'h6D;
      6: pattern = 7'h7D;
      7: pattern = 7'h07;
      8: pattern = 7'h7F;
      9: pattern = 7'h6F;
      default: pattern = 7'h00;
    endcase
    return ~{point, pattern};
  endfunction

  function automatic void owe_write(int unsigned position, logic [7:0] data, logic closes);
    out_item_t w;
    w.unit_index = position[4:1];
    w.port_b     = position[0];
    w.port_data  = data;
    w.last       = closes;
    display_writes_due.push_back(w);
  endfunction

  // Works out every display write that one accepted transaction causes.
  function automatic void predict_display_writes(in_item_t it);
    int unsigned fitted;
    logic [63:0] rest;
    logic        point;
    fitted = fitted_of(num_digits_shadow);
    case (it.mode)
      MODE_NUMBER: begin
        // Least significant digit first; digits past the display are lost,
        // and only the first eight positions have a point bit.
        rest = it.number;
        for (int unsigned i = 0; i < fitted; i++) begin
          point = (i < 8) ? it.dp_mask[i[2:0]] : 1'b0;
          owe_write(i, lit_segments(int'(rest % 10), point), i == fitted - 1);
          rest = rest / 10;
        end
      end
      MODE_DIGIT: begin
        if (it.digit_value <= 9 && it.digit_index < fitted) begin
          owe_write(it.digit_index, lit_segments(it.digit_value, it.digit_dp), 1'b1);
        end
      end
      MODE_RAW: begin
        if (it.digit_index < fitted) begin
          owe_write(it.digit_index, it.raw_byte, 1'b1);
        end
      end
      MODE_CLEAR: begin
        for (int unsigned i = 0; i < fitted; i++) begin
          owe_write(i, BLANK_BYTE, i == fitted - 1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Random transaction, mostly well formed for the given display size: the
  // index usually lands on a fitted digit and the digit value is usually
  // decimal, with the odd stray one mixed in.
  function automatic in_item_t random_item(int unsigned fitted);
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick < 3) begin
      it.mode = MODE_NUMBER;
    end else if (pick < 5) begin
      it.mode = MODE_DIGIT;
    end else if (pick < 7) begin
      it.mode = MODE_RAW;
    end else begin
      it.mode = MODE_CLEAR;
    end
    case ($urandom_range(0, 3))
      0: it.number = 64'($urandom_range(0, 9999));
      1: it.number = {32'h0, $urandom};
      default: it.number = {$urandom, $urandom};
    endcase
    it.dp_mask = 8'($urandom_range(0, 255));
    if (fitted == 0 || $urandom_range(0, 9) == 0) begin
      it.digit_index = 5'($urandom_range(0, 31));
    end else begin
      it.digit_index = 5'($urandom_range(0, fitted - 1));
    end
    if ($urandom_range(0, 9) == 0) begin
      it.digit_value = 4'($urandom_range(10, 15));
    end else begin
      it.digit_value = 4'($urandom_range(0, 9));
    end
    it.digit_dp = 1'($urandom_range(0, 1));
    it.raw_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic queue_item(in_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_fields(mode_e m, logic [63:0] num, logic [7:0] dpm, logic [4:0] idx,
                              logic [3:0] val, logic dp, logic [7:0] raw);
    in_item_t it;
    it.mode        = m;
    it.number      = num;
    it.dp_mask     = dpm;
    it.digit_index = idx;
    it.digit_value = val;
    it.digit_dp    = dp;
    it.raw_byte    = raw;
    queue_item(it);
  endtask

  // Waits until every queued transaction has gone in and every display write
  // has come out, then lets the block settle in case the last transaction
  // produced nothing.
  task automatic drain();
    while (items_accepted != items_queued || display_writes_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Only ever called with the block idle.
  task automatic write_num_digits(logic [4:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    num_digits_shadow = value;
  endtask

  // Sender: one transaction at a time, a drawn gap after each acceptance.
  // A payload that has not been taken yet is held exactly as it is.
  int unsigned send_wait = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && items_accepted != items_offered) begin
        // Still stalled; keep offering the same transaction.
      end else if (send_wait > 0) begin
        in_valid_i <= 1'b0;
        send_wait--;
      end else if (pending_items.size() != 0) begin
        in_data_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        items_offered++;
        send_wait = $urandom_range(0, send_gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: a drawn stall before each display write, and on request one
  // long hold-off that lets the block back up into its input.
  int unsigned writes_seen = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (writes_taken != writes_seen) begin
        writes_seen = writes_taken;
        stall_left = $urandom_range(0, recv_gap_max);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Both handshakes are sampled at the rising edge. An accepted input
  // transaction is predicted at once; an accepted display write is compared
  // with the oldest one owed.
  always @(posedge clk_i) begin
    out_item_t owed;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_display_writes(in_data_i);
        items_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        writes_taken++;
        if (display_writes_due.size() == 0) begin
          $error("display write with none owed: unit %0d port_b %0d data %02h last %0d",
                 out_data_o.unit_index, out_data_o.port_b, out_data_o.port_data,
                 out_data_o.last);
          error_count++;
        end else begin
          owed = display_writes_due.pop_front();
          if (out_data_o.unit_index !== owed.unit_index) begin
            $error("unit_index: expected %0d, got %0d", owed.unit_index, out_data_o.unit_index);
            error_count++;
          end
          if (out_data_o.port_b !== owed.port_b) begin
            $error("port_b: expected %0d, got %0d", owed.port_b, out_data_o.port_b);
            error_count++;
          end
          if (out_data_o.port_data !== owed.port_data) begin
            $error("port_data: expected %02h, got %02h", owed.port_data, out_data_o.port_data);
            error_count++;
          end
          if (out_data_o.last !== owed.last) begin
            $error("last: expected %0d, got %0d", owed.last, out_data_o.last);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [4:0]  count;
    int unsigned fitted;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part with the reset digit count of eight and no idling.
    queue_fields(MODE_NUMBER, 64'd0, 8'h00, 5'd0, 4'd0, 1'b0, 8'h00);
    queue_fields(MODE_NUMBER, '1, 8'hFF, 5'd31, 4'd15, 1'b1, 8'hFF);
    queue_fields(MODE_NUMBER, 64'd12345678, 8'hA5, 5'd3, 4'd2, 1'b0, 8'h11);
    // More decimal digits than the display has: the top ones are dropped.
    queue_fields(MODE_NUMBER, 64'd987654321, 8'h5A, 5'd0, 4'd0, 1'b0, 8'h00);
    queue_fields(MODE_DIGIT, 64'd0, 8'h00, 5'd0, 4'd0, 1'b0, 8'h00);
    queue_fields(MODE_DIGIT, '1, 8'hFF, 5'd7, 4'd9, 1'b1, 8'hFF);
    // Digit values past nine are ignored.
    queue_fields(MODE_DIGIT, 64'd0, 8'h00, 5'd2, 4'd10, 1'b0, 8'h00);
    queue_fields(MODE_DIGIT, 64'd0, 8'h00, 5'd2, 4'd15, 1'b1, 8'h00);
    // Indexes at or past the digit count are ignored.
    queue_fields(MODE_DIGIT, 64'd0, 8'h00, 5'd8, 4'd4, 1'b0, 8'h00);
    queue_fields(MODE_DIGIT, 64'd0, 8'h00, 5'd31, 4'd4, 1'b0, 8'h00);
    queue_fields(MODE_RAW, 64'd0, 8'h00, 5'd0, 4'd0, 1'b0, 8'h00);
    queue_fields(MODE_RAW, 64'd0, 8'h00, 5'd7, 4'd0, 1'b0, 8'hFF);
    queue_fields(MODE_RAW, 64'd0, 8'h00, 5'd8, 4'd0, 1'b0, 8'h3C);
    queue_fields(MODE_CLEAR, 64'd0, 8'h00, 5'd0, 4'd0, 1'b0, 8'h00);
    drain();

    // Largest display: positions beyond eight never show a point.
    write_num_digits(5'd20);
    queue_fields(MODE_NUMBER, '1, 8'hFF, 5'd0, 4'd0, 1'b0, 8'h00);
    queue_fields(MODE_DIGIT, 64'd0, 8'h00, 5'd19, 4'd5, 1'b1, 8'h00);
    queue_fields(MODE_DIGIT, 64'd0, 8'h00, 5'd20, 4'd5, 1'b1, 8'h00);
    queue_fields(MODE_RAW, 64'd0, 8'h00, 5'd19, 4'd0, 1'b0, 8'h5A);
    queue_fields(MODE_CLEAR, 64'd0, 8'h00, 5'd0, 4'd0, 1'b0, 8'h00);
    drain();

    // No digits fitted: nothing comes out in any mode.
    write_num_digits(5'd0);
    queue_fields(MODE_NUMBER, 64'd42, 8'hFF, 5'd0, 4'd0, 1'b0, 8'h00);
    queue_fields(MODE_DIGIT, 64'd0, 8'h00, 5'd0, 4'd3, 1'b0, 8'h00);
    queue_fields(MODE_RAW, 64'd0, 8'h00, 5'd0, 4'd0, 1'b0, 8'h77);
    queue_fields(MODE_CLEAR, 64'd0, 8'h00, 5'd0, 4'd0, 1'b0, 8'h00);
    drain();

    // A count above the largest display behaves as the largest display.
    write_num_digits(5'd31);
    queue_fields(MODE_NUMBER, '1, 8'h81, 5'd0, 4'd0, 1'b0, 8'h00);
    queue_fields(MODE_RAW, 64'd0, 8'h00, 5'd19, 4'd0, 1'b0, 8'hC3);
    queue_fields(MODE_RAW, 64'd0, 8'h00, 5'd20, 4'd0, 1'b0, 8'hC3);
    queue_fields(MODE_CLEAR, 64'd0, 8'h00, 5'd0, 4'd0, 1'b0, 8'h00);
    drain();

    // Random part: a new display size for each phase, and the idling pattern
    // rotating so that gaps fall on every stage of the block's work.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (phase_counts[p] == 0) begin
        count = 5'($urandom_range(2, 19));
      end else begin
        count = 5'(phase_counts[p]);
      end
      write_num_digits(count);
      fitted = fitted_of(count);
      case (p % 4)
        0: begin
          send_gap_max = 0;
          recv_gap_max = 0;
        end
        1: begin
          send_gap_max = 14;
          recv_gap_max = 14;
        end
        2: begin
          send_gap_max = 0;
          recv_gap_max = 14;
        end
        default: begin
          send_gap_max = 14;
          recv_gap_max = 0;
        end
      endcase
      for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
        queue_item(random_item(fitted));
      end
      // Once, the receiver holds off for a long stretch while the sender
      // keeps offering back to back, so the block fills and stalls its input.
      if (p == 2) begin
        hold_requests++;
      end
      drain();
    end

    if (display_writes_due.size() != 0) begin
      $error("%0d display writes never arrived", display_writes_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
